// File: rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, codes and character helpers for the HTTP request header
// parser: parse phases, result kinds, status codes and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

   localparam int MAX_HEADER_DEFAULT = 4096;
   localparam int LEN_W = 13;
   localparam int MAX_RESULTS = 3;

   localparam logic [LEN_W-1:0] HEADER_LIMIT_RESET = 13'd4096;
   localparam logic [LEN_W-1:0] TARGET_LIMIT_RESET = 13'd4096;
   localparam logic [LEN_W-1:0] FIELD_LIMIT_RESET  = 13'd256;
   localparam logic [LEN_W-1:0] LEN_SAT            = 13'd8191;

   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [31:0] END_OF_HEADER = 32'h0D0A0D0A;

   // register index codes on the configuration port
   localparam logic [1:0] REG_HEADER_LIMIT = 2'd0;
   localparam logic [1:0] REG_TARGET_LIMIT = 2'd1;
   localparam logic [1:0] REG_FIELD_LIMIT  = 2'd2;

   typedef enum logic [3:0] {
      PH_METHOD, PH_GET, PH_HEAD, PH_MSPACE, PH_TARGET, PH_PROTO, PH_VERSION,
      PH_REQCR, PH_REQLF, PH_NAME, PH_COLON, PH_BLANKS, PH_VALUE, PH_SKIP,
      PH_ENDED
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TARGET = 2'd0,
      KIND_HOST_START = 2'd1,
      KIND_HOST = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_BAD = 3'd1,
      ST_METHOD = 3'd2,
      ST_LARGE = 3'd3,
      ST_VERSION = 3'd4
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      status_type status;
      logic       method_head;
   } result_type;

   typedef struct packed {
      logic [1:0]       count;
      result_type [2:0] slot;
   } bundle_type;

   function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
      return (v == LEN_SAT) ? v : v + 13'd1;
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic [7:0] get_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0: r = 8'h45;   // E
         3'd1: r = 8'h54;   // T
         default: r = 8'hFF;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] head_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0: r = 8'h45;   // E
         3'd1: r = 8'h41;   // A
         3'd2: r = 8'h44;   // D
         default: r = 8'hFF;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] proto_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0: r = 8'h48;   // H
         3'd1: r = 8'h54;   // T
         3'd2: r = 8'h54;   // T
         3'd3: r = 8'h50;   // P
         3'd4: r = 8'h2F;   // /
         default: r = 8'hFF;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] host_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0: r = 8'h68;   // h
         3'd1: r = 8'h6F;   // o
         3'd2: r = 8'h73;   // s
         3'd3: r = 8'h74;   // t
         default: r = 8'hFF;
      endcase
      return r;
   endfunction

   // status for text that stops where the phase stands
   function automatic status_type end_status(input phase_type ph, input logic [2:0] m);
      status_type r;
      if (ph == PH_NAME && m == 3'd0) begin
         r = ST_OK;
      end else if (ph inside {PH_METHOD, PH_GET, PH_HEAD}) begin
         r = ST_METHOD;
      end else if (ph == PH_VERSION) begin
         r = ST_VERSION;
      end else begin
         r = ST_BAD;
      end
      return r;
   endfunction

   function automatic result_type mk_res(input kind_type k, input logic [7:0] b,
                                          input status_type s, input logic mh);
      result_type r;
      r.kind = k;
      r.out_byte = b;
      r.status = s;
      r.method_head = mh;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/hrhp_if.sv
// ----------------------------------------------------------------------------
// hrhp_if
// Valid/ready channels of the HTTP request header parser: the request byte
// channel and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_data;

   modport source (output valid, data_byte, end_of_data, input ready);
   modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface hrhp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic       method_head;
   logic       last;

   modport source (output valid, kind, out_byte, status, method_head, last, input ready);
   modport sink   (input valid, kind, out_byte, status, method_head, last, output ready);
endinterface

`default_nettype wire

// File: rtl/hrhp_rsp_queue.sv
// ----------------------------------------------------------------------------
// hrhp_rsp_queue
// Two-entry queue of result bundles (up to three results per request byte),
// drained one result per beat onto the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_rsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire hrhp_pkg::bundle_type push_bundle,
   output logic                    push_ready,
   hrhp_rsp_if.source              rsp
);

   hrhp_pkg::bundle_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic [1:0] sel_ff, sel_in;

   hrhp_pkg::bundle_type head;
   hrhp_pkg::result_type cur;
   logic push, beat, pop, last_res;

   assign push_ready = (fill_ff != 2'd2);
   assign push       = push_valid & push_ready;

   assign head     = entry_ff[rd_ptr_ff];
   assign cur      = head.slot[sel_ff];
   assign last_res = (sel_ff == (head.count - 2'd1));

   assign rsp.valid       = (fill_ff != 2'd0);
   assign rsp.kind        = cur.kind;
   assign rsp.out_byte    = cur.out_byte;
   assign rsp.status      = cur.status;
   assign rsp.method_head = cur.method_head;
   assign rsp.last        = last_res;

   assign beat = rsp.valid & rsp.ready;
   assign pop  = beat & last_res;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
      sel_in    = sel_ff;
      if (pop) begin
         sel_in = 2'd0;
      end else if (beat) begin
         sel_in = sel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
         sel_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         sel_ff    <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

`default_nettype wire

// File: rtl/http_request_header_parser.sv
// ----------------------------------------------------------------------------
// http_request_header_parser
// Checks an HTTP/1.x request line and Host headers byte by byte, streams the
// decoded target and Host values, and reports one final status per request.
// ----------------------------------------------------------------------------
// Usage:
//   req : one request byte per beat (data_byte), or end_of_data with no byte.
//   rsp : results: target bytes, host-value start, host bytes and a final
//         status; last marks the final result caused by one request byte.
//   csr : APB-style limits: header_limit at 0x0, target_limit at 0x4,
//         field_limit at 0x8; write only while the block is idle.
// A request byte is parsed in the cycle it is accepted; its results appear
// on rsp from the next cycle, one per cycle while rsp is ready. A byte is
// accepted every cycle while rsp is ready and each byte yields at most one
// result; a byte that yields two or three results holds the output until
// each is taken, and a two-bundle result queue absorbs the difference. When
// rsp stalls the queue fills and req.ready drops; nothing is lost. Reset
// returns the parser to the start of a request and the limits to 4096, 4096
// and 256. After each status the parser starts over with the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_header_parser #(
   parameter int MAX_HEADER = hrhp_pkg::MAX_HEADER_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hrhp_req_if.sink         req,
   hrhp_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int LimW = $clog2(MAX_HEADER + 1);
   localparam int CmpW = (LimW > hrhp_pkg::LEN_W) ? LimW : hrhp_pkg::LEN_W;

   // configuration
   logic [12:0] hlim_ff, tlim_ff, flim_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         hlim_ff <= hrhp_pkg::HEADER_LIMIT_RESET;
         tlim_ff <= hrhp_pkg::TARGET_LIMIT_RESET;
         flim_ff <= hrhp_pkg::FIELD_LIMIT_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            hrhp_pkg::REG_HEADER_LIMIT: hlim_ff <= csr_pwdata[12:0];
            hrhp_pkg::REG_TARGET_LIMIT: tlim_ff <= csr_pwdata[12:0];
            hrhp_pkg::REG_FIELD_LIMIT:  flim_ff <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         hrhp_pkg::REG_HEADER_LIMIT: csr_prdata = {19'd0, hlim_ff};
         hrhp_pkg::REG_TARGET_LIMIT: csr_prdata = {19'd0, tlim_ff};
         hrhp_pkg::REG_FIELD_LIMIT:  csr_prdata = {19'd0, flim_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // parser state
   hrhp_pkg::phase_type  phase_ff, phase_in;
   logic [12:0]          bcount_ff, bcount_in;
   logic [23:0]          tail_ff, tail_in;
   logic [2:0]           match_ff, match_in;
   logic [12:0]          tlen_ff, tlen_in;
   logic [12:0]          vlen_ff, vlen_in;
   logic [1:0]           pend_ff, pend_in;
   logic [7:0]           held_ff, held_in;
   hrhp_pkg::status_type err_ff, err_in;
   logic                 head_ff, head_in;

   // working signals
   logic                 accept;
   logic [7:0]           c, lc;
   logic [31:0]          window;
   logic                 prev_cr;
   logic [4:0]           hv, held_hv;
   logic                 tgt_ok_cur, tgt_ok_next, handled, value_go;
   logic [12:0]          v1, v2;
   logic [CmpW-1:0]      limit, bcount_w;
   logic                 do_parse, do_finish, too_large;
   hrhp_pkg::status_type fin_status;
   logic [1:0]           nres;
   hrhp_pkg::result_type [3:0] res;
   hrhp_pkg::bundle_type bundle;
   logic                 q_ready;

   function automatic logic fits(input logic [12:0] len, input logic [12:0] lim);
      return ({1'b0, len} + 14'd1) <= {1'b0, lim};
   endfunction

   assign accept   = req.valid & req.ready;
   assign req.ready = q_ready;
   assign c        = req.data_byte;
   assign window   = {tail_ff, c};
   assign prev_cr  = (tail_ff[7:0] == hrhp_pkg::CH_CR);
   assign lc       = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   assign hv       = hrhp_pkg::hex_val(c);
   assign held_hv  = hrhp_pkg::hex_val(held_ff);
   assign limit    = (CmpW'(hlim_ff) < CmpW'(MAX_HEADER)) ? CmpW'(hlim_ff) : CmpW'(MAX_HEADER);
   assign bcount_w = CmpW'(hrhp_pkg::sat_inc(bcount_ff));
   assign tgt_ok_cur  = fits(tlen_ff, tlim_ff);
   assign tgt_ok_next = fits(hrhp_pkg::sat_inc(tlen_ff), tlim_ff);

   always_comb begin
      phase_in   = phase_ff;
      bcount_in  = bcount_ff;
      tail_in    = tail_ff;
      match_in   = match_ff;
      tlen_in    = tlen_ff;
      vlen_in    = vlen_ff;
      pend_in    = pend_ff;
      held_in    = held_ff;
      err_in     = err_ff;
      head_in    = head_ff;
      nres       = 2'd0;
      res        = '0;
      handled    = 1'b0;
      value_go   = 1'b0;
      v1         = vlen_ff;
      v2         = vlen_ff;
      do_parse   = 1'b0;
      do_finish  = 1'b0;
      too_large  = 1'b0;
      fin_status = hrhp_pkg::ST_OK;

      if (accept) begin
         if (req.end_of_data) begin
            do_finish = 1'b1;
         end else begin
            bcount_in = hrhp_pkg::sat_inc(bcount_ff);
            tail_in   = window[23:0];
            if (window == hrhp_pkg::END_OF_HEADER) begin
               do_parse  = 1'b1;
               do_finish = 1'b1;
            end else if (bcount_w >= limit) begin
               do_finish = 1'b1;
               too_large = 1'b1;
            end else begin
               do_parse = 1'b1;
            end
         end
      end

      if (do_parse && phase_ff != hrhp_pkg::PH_ENDED) begin
         if (c == hrhp_pkg::CH_NUL) begin
            err_in   = hrhp_pkg::end_status(phase_ff, match_ff);
            phase_in = hrhp_pkg::PH_ENDED;
         end else begin
            case (phase_ff)
               hrhp_pkg::PH_METHOD: begin
                  match_in = 3'd0;
                  if (c == 8'h47) begin
                     phase_in = hrhp_pkg::PH_GET;
                  end else if (c == 8'h48) begin
                     phase_in = hrhp_pkg::PH_HEAD;
                  end else begin
                     err_in   = hrhp_pkg::ST_METHOD;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end
               end
               hrhp_pkg::PH_GET: begin
                  if (match_ff < 3'd2 && c == hrhp_pkg::get_char(match_ff)) begin
                     match_in = match_ff + 3'd1;
                     if (match_ff == 3'd1) begin
                        head_in  = 1'b0;
                        phase_in = hrhp_pkg::PH_MSPACE;
                     end
                  end else begin
                     err_in   = hrhp_pkg::ST_METHOD;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end
               end
               hrhp_pkg::PH_HEAD: begin
                  if (match_ff < 3'd3 && c == hrhp_pkg::head_char(match_ff)) begin
                     match_in = match_ff + 3'd1;
                     if (match_ff == 3'd2) begin
                        head_in  = 1'b1;
                        phase_in = hrhp_pkg::PH_MSPACE;
                     end
                  end else begin
                     err_in   = hrhp_pkg::ST_METHOD;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end
               end
               hrhp_pkg::PH_MSPACE: begin
                  if (c == hrhp_pkg::CH_SPACE) begin
                     phase_in = hrhp_pkg::PH_TARGET;
                     tlen_in  = 13'd0;
                     pend_in  = 2'd0;
                  end else begin
                     err_in   = hrhp_pkg::ST_BAD;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end
               end
               hrhp_pkg::PH_TARGET: begin
                  if (c == hrhp_pkg::CH_SPACE) begin
                     // flush a stray percent before closing the target
                     if (pend_ff != 2'd0 && tgt_ok_cur) begin
                        res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_TARGET,
                           hrhp_pkg::CH_PERCENT, hrhp_pkg::ST_OK, 1'b0);
                        nres = nres + 2'd1;
                     end
                     if (pend_ff == 2'd2 && tgt_ok_cur) begin
                        res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_TARGET,
                           held_ff, hrhp_pkg::ST_OK, 1'b0);
                        nres = nres + 2'd1;
                     end
                     pend_in = 2'd0;
                     if (!tgt_ok_cur) begin
                        err_in   = hrhp_pkg::ST_LARGE;
                        phase_in = hrhp_pkg::PH_ENDED;
                     end else begin
                        phase_in = hrhp_pkg::PH_PROTO;
                        match_in = 3'd0;
                     end
                  end else if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF) begin
                     err_in   = hrhp_pkg::ST_BAD;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end else begin
                     tlen_in = hrhp_pkg::sat_inc(tlen_ff);
                     if (pend_ff == 2'd1) begin
                        if (hv[4]) begin
                           held_in = c;
                           pend_in = 2'd2;
                           handled = 1'b1;
                        end else begin
                           if (tgt_ok_next) begin
                              res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_TARGET,
                                 hrhp_pkg::CH_PERCENT, hrhp_pkg::ST_OK, 1'b0);
                              nres = nres + 2'd1;
                           end
                           pend_in = 2'd0;
                        end
                     end else if (pend_ff == 2'd2) begin
                        if (hv[4]) begin
                           if (tgt_ok_next) begin
                              res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_TARGET,
                                 {held_hv[3:0], hv[3:0]}, hrhp_pkg::ST_OK, 1'b0);
                              nres = nres + 2'd1;
                           end
                           pend_in = 2'd0;
                           handled = 1'b1;
                        end else begin
                           if (tgt_ok_next) begin
                              res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_TARGET,
                                 hrhp_pkg::CH_PERCENT, hrhp_pkg::ST_OK, 1'b0);
                              nres = nres + 2'd1;
                              res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_TARGET,
                                 held_ff, hrhp_pkg::ST_OK, 1'b0);
                              nres = nres + 2'd1;
                           end
                           pend_in = 2'd0;
                        end
                     end
                     if (!handled) begin
                        if (c == hrhp_pkg::CH_PERCENT) begin
                           pend_in = 2'd1;
                        end else if (tgt_ok_next) begin
                           res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_TARGET,
                              (c == hrhp_pkg::CH_PLUS) ? hrhp_pkg::CH_SPACE : c,
                              hrhp_pkg::ST_OK, 1'b0);
                           nres = nres + 2'd1;
                        end
                     end
                  end
               end
               hrhp_pkg::PH_PROTO: begin
                  if (match_ff < 3'd5 && c == hrhp_pkg::proto_char(match_ff)) begin
                     match_in = match_ff + 3'd1;
                     if (match_ff == 3'd4) begin
                        phase_in = hrhp_pkg::PH_VERSION;
                        match_in = 3'd0;
                     end
                  end else begin
                     err_in   = hrhp_pkg::ST_BAD;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end
               end
               hrhp_pkg::PH_VERSION: begin
                  if (match_ff == 3'd0 && c == 8'h31) begin
                     match_in = 3'd1;
                  end else if (match_ff == 3'd1 && c == 8'h2E) begin
                     match_in = 3'd2;
                  end else if (match_ff == 3'd2 && (c == 8'h30 || c == 8'h31)) begin
                     phase_in = hrhp_pkg::PH_REQCR;
                  end else begin
                     err_in   = hrhp_pkg::ST_VERSION;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end
               end
               hrhp_pkg::PH_REQCR: begin
                  if (c == hrhp_pkg::CH_CR) begin
                     phase_in = hrhp_pkg::PH_REQLF;
                  end else begin
                     err_in   = hrhp_pkg::ST_BAD;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end
               end
               hrhp_pkg::PH_REQLF: begin
                  if (c == hrhp_pkg::CH_LF) begin
                     phase_in = hrhp_pkg::PH_NAME;
                     match_in = 3'd0;
                  end else begin
                     err_in   = hrhp_pkg::ST_BAD;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end
               end
               hrhp_pkg::PH_NAME: begin
                  if (match_ff < 3'd4 && lc == hrhp_pkg::host_char(match_ff)) begin
                     match_in = match_ff + 3'd1;
                     if (match_ff == 3'd3) begin
                        phase_in = hrhp_pkg::PH_COLON;
                     end
                  end else begin
                     phase_in = hrhp_pkg::PH_SKIP;
                  end
               end
               hrhp_pkg::PH_COLON: begin
                  if (c == hrhp_pkg::CH_COLON) begin
                     res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_HOST_START, 8'd0,
                        hrhp_pkg::ST_OK, 1'b0);
                     nres     = nres + 2'd1;
                     vlen_in  = 13'd0;
                     phase_in = hrhp_pkg::PH_BLANKS;
                  end else begin
                     err_in   = hrhp_pkg::ST_BAD;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end
               end
               hrhp_pkg::PH_BLANKS: begin
                  // skip leading blanks, then treat as a value byte
                  if (c != hrhp_pkg::CH_SPACE && c != hrhp_pkg::CH_TAB) begin
                     phase_in = hrhp_pkg::PH_VALUE;
                     value_go = 1'b1;
                  end
               end
               hrhp_pkg::PH_VALUE: begin
                  value_go = 1'b1;
               end
               hrhp_pkg::PH_SKIP: begin
                  if (c == hrhp_pkg::CH_LF && prev_cr) begin
                     phase_in = hrhp_pkg::PH_NAME;
                     match_in = 3'd0;
                  end
               end
               default: begin
                  phase_in = hrhp_pkg::PH_ENDED;
               end
            endcase

            if (value_go) begin
               if (prev_cr && c == hrhp_pkg::CH_LF) begin
                  if (!fits(vlen_ff, flim_ff)) begin
                     err_in   = hrhp_pkg::ST_LARGE;
                     phase_in = hrhp_pkg::PH_ENDED;
                  end else begin
                     phase_in = hrhp_pkg::PH_NAME;
                     match_in = 3'd0;
                  end
               end else begin
                  // a held CR that was not a line end is value data
                  v1 = prev_cr ? hrhp_pkg::sat_inc(vlen_ff) : vlen_ff;
                  if (prev_cr && fits(v1, flim_ff)) begin
                     res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_HOST,
                        hrhp_pkg::CH_CR, hrhp_pkg::ST_OK, 1'b0);
                     nres = nres + 2'd1;
                  end
                  v2 = (c != hrhp_pkg::CH_CR) ? hrhp_pkg::sat_inc(v1) : v1;
                  if (c != hrhp_pkg::CH_CR && fits(v2, flim_ff)) begin
                     res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_HOST, c,
                        hrhp_pkg::ST_OK, 1'b0);
                     nres = nres + 2'd1;
                  end
                  vlen_in = v2;
               end
            end
         end
      end

      if (do_finish) begin
         if (too_large) begin
            fin_status = hrhp_pkg::ST_LARGE;
         end else if (bcount_in < 13'd2) begin
            fin_status = hrhp_pkg::ST_BAD;
         end else if (phase_in == hrhp_pkg::PH_ENDED) begin
            fin_status = err_in;
         end else begin
            fin_status = hrhp_pkg::end_status(phase_in, match_in);
         end
         res[nres] = hrhp_pkg::mk_res(hrhp_pkg::KIND_STATUS, 8'd0, fin_status, head_in);
         nres      = nres + 2'd1;
         // start over for the next request
         phase_in  = hrhp_pkg::PH_METHOD;
         bcount_in = 13'd0;
         tail_in   = 24'd0;
         match_in  = 3'd0;
         tlen_in   = 13'd0;
         vlen_in   = 13'd0;
         pend_in   = 2'd0;
         held_in   = 8'd0;
         err_in    = hrhp_pkg::ST_OK;
         head_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hrhp_pkg::PH_METHOD;
         bcount_ff <= 13'd0;
         tail_ff   <= 24'd0;
         match_ff  <= 3'd0;
         tlen_ff   <= 13'd0;
         vlen_ff   <= 13'd0;
         pend_ff   <= 2'd0;
         held_ff   <= 8'd0;
         err_ff    <= hrhp_pkg::ST_OK;
         head_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         bcount_ff <= bcount_in;
         tail_ff   <= tail_in;
         match_ff  <= match_in;
         tlen_ff   <= tlen_in;
         vlen_ff   <= vlen_in;
         pend_ff   <= pend_in;
         held_ff   <= held_in;
         err_ff    <= err_in;
         head_ff   <= head_in;
      end
   end

   assign bundle.count = nres;
   assign bundle.slot  = res[2:0];

   hrhp_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (accept && nres != 2'd0),
      .push_bundle (bundle),
      .push_ready  (q_ready),
      .rsp         (rsp)
   );

endmodule

`default_nettype wire

// File: rtl/hrhp_checker.sv
// ----------------------------------------------------------------------------
// hrhp_checker
// Port-level checks of the HTTP request header parser result channel,
// bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_out_byte,
   input wire logic [2:0] rsp_status,
   input wire logic       rsp_method_head,
   input wire logic       rsp_last
);

   // nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown in the cycle after reset");

   // a status closes the results of its byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == hrhp_pkg::KIND_STATUS |-> rsp_last)
      else $error("status result not marked last");

   a_data_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != hrhp_pkg::KIND_STATUS |->
         rsp_status == hrhp_pkg::ST_OK && !rsp_method_head)
      else $error("status fields set on a data result");

   a_host_start_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == hrhp_pkg::KIND_HOST_START |-> rsp_out_byte == 8'd0)
      else $error("host start carries a byte");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_byte) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

endmodule

bind http_request_header_parser hrhp_checker u_hrhp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_kind        (rsp.kind),
   .rsp_out_byte    (rsp.out_byte),
   .rsp_status      (rsp.status),
   .rsp_method_head (rsp.method_head),
   .rsp_last        (rsp.last)
);

`default_nettype wire
